[hdl/sorted_list_insert_remove_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sorted list block
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_INSERT_REMOVE_DEFINES_SVH
`define SORTED_LIST_INSERT_REMOVE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SLI_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sorted list check failed");

// next-cycle implication
`define SLI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorted list check failed");

`else

`define SLI_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SLI_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[hdl/sli_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted list package
// Shared widths, command and status codes, and the operation code broadcast
// to every cell.
// ----------------------------------------------------------------------------
`default_nettype none

package sli_pkg;

   localparam int ENTRY_W = 32;
   localparam int COUNT_W = 5;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef enum logic [1:0] {
      CMD_INSERT,
      CMD_REMOVE,
      CMD_DUMP,
      CMD_SPARE
   } list_cmd_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_ROTATE
   } cell_op_type;

endpackage

`default_nettype wire

[hdl/sli_cell.sv]
// ----------------------------------------------------------------------------
// Sorted list cell
// Holds one table entry and its valid flag; shifts with its neighbours.
// ----------------------------------------------------------------------------
`default_nettype none

module sli_cell import sli_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  cell_op_type               op,
   input  logic signed [ENTRY_W-1:0] cmp_value,
   input  logic signed [ENTRY_W-1:0] left_entry,
   input  logic                      left_valid,
   input  logic                      left_move,
   input  logic signed [ENTRY_W-1:0] right_entry,
   input  logic                      right_valid,
   input  logic signed [ENTRY_W-1:0] wrap_entry,
   output logic signed [ENTRY_W-1:0] entry,
   output logic                      valid,
   output logic                      move,
   output logic                      match
);

   logic signed [ENTRY_W-1:0] entry_ff;
   logic signed [ENTRY_W-1:0] entry_in;
   logic                      valid_ff;
   logic                      valid_in;
   logic                      ge;

   always_comb begin
      // an empty slot or a larger entry makes room for an insert
      move  = !valid_ff || (entry_ff > cmp_value);
      ge    = valid_ff && (entry_ff >= cmp_value);
      match = valid_ff && (entry_ff == cmp_value);

      entry_in = entry_ff;
      valid_in = valid_ff;
      case (op)
         CELL_INSERT: begin
            if (move) begin
               entry_in = left_move ? left_entry : cmp_value;
               valid_in = valid_ff || left_valid;
            end
         end
         CELL_REMOVE: begin
            if (ge) begin
               entry_in = right_entry;
               valid_in = right_valid;
            end
         end
         CELL_ROTATE: begin
            // the head entry wraps round to the top valid cell of the list
            if (valid_ff) begin
               entry_in = right_valid ? right_entry : wrap_entry;
            end
         end
         default: begin
            entry_in = entry_ff;
            valid_in = valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign valid = valid_ff;

endmodule

`default_nettype wire

[hdl/sorted_list_insert_remove.sv]
// ----------------------------------------------------------------------------
// Sorted list with insert and remove
// Ascending table of signed 32-bit values held in a chain of cells.
// ----------------------------------------------------------------------------
// The table lives in CAPACITY cells, each comparing its entry with a broadcast
// value and shifting to a neighbour. An insert (and an unused command code)
// is answered directly from the idle state. A remove enters its own state, in
// which the chain drops one equal entry per cycle; once none is left, the
// result is given when the output register is free. A dump of an empty table
// is answered from the idle state; otherwise the chain rotates one place per
// transfer and cell 0 feeds the single output register. No new command is
// taken until the current one has given its last result; the output register
// can be reloaded in the cycle its previous result is taken.
`default_nettype none
`include "sorted_list_insert_remove_defines.svh"

module sorted_list_insert_remove import sli_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_cmd,
   input  logic signed [ENTRY_W-1:0] req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [ENTRY_W-1:0] rsp_entry_value,
   output logic                      rsp_has_value,
   output logic                      rsp_last,
   output logic                      rsp_status,
   output logic [COUNT_W-1:0]        rsp_count
);

   localparam int FILL_W = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REMOVE,
      ST_DUMP
   } state_type;

   state_type                 state_ff;
   state_type                 state_in;
   logic [FILL_W-1:0]         fill_ff;
   logic [FILL_W-1:0]         fill_in;
   logic [FILL_W-1:0]         remain_ff;
   logic [FILL_W-1:0]         remain_in;
   logic signed [ENTRY_W-1:0] value_ff;
   logic signed [ENTRY_W-1:0] value_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic signed [ENTRY_W-1:0] rsp_entry_value_ff;
   logic signed [ENTRY_W-1:0] rsp_entry_value_in;
   logic                      rsp_has_value_ff;
   logic                      rsp_has_value_in;
   logic                      rsp_last_ff;
   logic                      rsp_last_in;
   logic                      rsp_status_ff;
   logic                      rsp_status_in;
   logic [COUNT_W-1:0]        rsp_count_ff;
   logic [COUNT_W-1:0]        rsp_count_in;

   logic                      out_free;
   logic                      req_fire;
   logic                      full;
   logic                      hit;
   cell_op_type               cell_op;
   logic signed [ENTRY_W-1:0] cmp_value;

   logic signed [ENTRY_W-1:0] entry_w [CAPACITY];
   logic [CAPACITY-1:0]       valid_w;
   logic [CAPACITY-1:0]       move_w;
   logic [CAPACITY-1:0]       match_w;

   // ------------------------------------------------------------------------
   // cell chain
   // ------------------------------------------------------------------------
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [ENTRY_W-1:0] left_entry;
      logic                      left_valid;
      logic                      left_move;
      logic signed [ENTRY_W-1:0] right_entry;
      logic                      right_valid;

      if (g == 0) begin : g_head
         assign left_entry = '0;
         assign left_valid = 1'b1;
         assign left_move  = 1'b0;
      end else begin : g_body
         assign left_entry = entry_w[g-1];
         assign left_valid = valid_w[g-1];
         assign left_move  = move_w[g-1];
      end

      if (g == CAPACITY - 1) begin : g_tail
         assign right_entry = '0;
         assign right_valid = 1'b0;
      end else begin : g_link
         assign right_entry = entry_w[g+1];
         assign right_valid = valid_w[g+1];
      end

      sli_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .op          (cell_op),
         .cmp_value   (cmp_value),
         .left_entry  (left_entry),
         .left_valid  (left_valid),
         .left_move   (left_move),
         .right_entry (right_entry),
         .right_valid (right_valid),
         .wrap_entry  (entry_w[0]),
         .entry       (entry_w[g]),
         .valid       (valid_w[g]),
         .move        (move_w[g]),
         .match       (match_w[g])
      );
   end

   // ------------------------------------------------------------------------
   // control
   // ------------------------------------------------------------------------
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign req_fire  = req_valid && !req_stall;
   assign full      = (fill_ff == FILL_W'(CAPACITY));
   assign hit       = |match_w;
   assign cmp_value = (state_ff == ST_IDLE) ? req_value : value_ff;

   always_comb begin
      state_in           = state_ff;
      fill_in            = fill_ff;
      remain_in          = remain_ff;
      value_in           = value_ff;
      cell_op            = CELL_HOLD;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_entry_value_in = rsp_entry_value_ff;
      rsp_has_value_in   = rsp_has_value_ff;
      rsp_last_in        = rsp_last_ff;
      rsp_status_in      = rsp_status_ff;
      rsp_count_in       = rsp_count_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rsp_entry_value_in = '0;
               rsp_has_value_in   = 1'b0;
               rsp_last_in        = 1'b1;
               rsp_status_in      = STATUS_OK;
               rsp_count_in       = COUNT_W'(fill_ff);
               case (req_cmd)
                  CMD_INSERT: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = full ? STATUS_FULL : STATUS_OK;
                     if (!full) begin
                        cell_op      = CELL_INSERT;
                        fill_in      = fill_ff + 1'b1;
                        rsp_count_in = COUNT_W'(fill_in);
                     end
                  end
                  CMD_REMOVE: begin
                     value_in = req_value;
                     state_in = ST_REMOVE;
                  end
                  CMD_DUMP: begin
                     if (fill_ff == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        remain_in = fill_ff;
                        state_in  = ST_DUMP;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_REMOVE: begin
            // drop one equal entry per cycle until none is left
            if (hit) begin
               cell_op = CELL_REMOVE;
               fill_in = fill_ff - 1'b1;
            end else if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_entry_value_in = '0;
               rsp_has_value_in   = 1'b0;
               rsp_last_in        = 1'b1;
               rsp_status_in      = STATUS_OK;
               rsp_count_in       = COUNT_W'(fill_ff);
               state_in           = ST_IDLE;
            end
         end
         ST_DUMP: begin
            // advance the ring one place per transfer
            if (out_free) begin
               cell_op            = CELL_ROTATE;
               rsp_valid_in       = 1'b1;
               rsp_entry_value_in = entry_w[0];
               rsp_has_value_in   = 1'b1;
               rsp_last_in        = (remain_ff == FILL_W'(1));
               rsp_status_in      = STATUS_OK;
               rsp_count_in       = COUNT_W'(fill_ff);
               remain_in          = remain_ff - 1'b1;
               if (remain_ff == FILL_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      value_ff           <= value_in;
      rsp_entry_value_ff <= rsp_entry_value_in;
      rsp_has_value_ff   <= rsp_has_value_in;
      rsp_last_ff        <= rsp_last_in;
      rsp_status_ff      <= rsp_status_in;
      rsp_count_ff       <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_entry_value = rsp_entry_value_ff;
   assign rsp_has_value   = rsp_has_value_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_count       = rsp_count_ff;

   // ------------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------------
   `SLI_ASSERT_IMPL(a_fill_bound, clock, reset, 1'b1, fill_ff <= FILL_W'(CAPACITY))
   `SLI_ASSERT_IMPL(a_fill_cells, clock, reset, 1'b1, $countones(valid_w) == fill_ff)
   `SLI_ASSERT_NEXT(a_remove_step, clock, reset, state_ff == ST_REMOVE && hit, fill_ff + 1'b1 == $past(fill_ff))
   `SLI_ASSERT_IMPL(a_dump_nonempty, clock, reset, state_ff == ST_DUMP, fill_ff != '0 && remain_ff != '0)
   `SLI_ASSERT_IMPL(a_entry_count, clock, reset, rsp_valid_ff && rsp_has_value_ff, rsp_count_ff != '0 || fill_ff > FILL_W'(31))

endmodule

`default_nettype wire

[tb/sv/sorted_list_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list result checker
// Watches both channels of the sorted list block, keeps its own copy of the
// ascending table and compares every result transfer with the oldest
// outstanding prediction.
// ----------------------------------------------------------------------------

module sorted_list_checker import sli_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic [1:0]                req_cmd,
   input  logic signed [ENTRY_W-1:0] req_value,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic signed [ENTRY_W-1:0] rsp_entry_value,
   input  logic                      rsp_has_value,
   input  logic                      rsp_last,
   input  logic                      rsp_status,
   input  logic [COUNT_W-1:0]        rsp_count,
   output int                        fail_count,
   output int                        pending
);

   localparam int PRINT_CAP = 100;

   typedef struct packed {
      logic signed [ENTRY_W-1:0] entry_value;
      logic                      has_value;
      logic                      last;
      logic                      status;
      logic [COUNT_W-1:0]        count;
   } list_rsp_type;

   logic signed [ENTRY_W-1:0] table_q [CAPACITY];
   int                        fill_q;
   list_rsp_type              expected_q [$];

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (fail_count < PRINT_CAP) begin
         $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      end
      fail_count++;
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch(what, got, want);
      end
   endtask

   // Update the table for one command and queue the results it causes.
   task automatic predict_command(input logic [1:0] cmd, input logic signed [ENTRY_W-1:0] val);
      list_rsp_type rsp;
      int           pos;
      int           keep;
      rsp = '0;
      rsp.last = 1'b1;
      case (list_cmd_type'(cmd))
         CMD_INSERT: begin
            if (fill_q >= CAPACITY) begin
               rsp.status = STATUS_FULL;
            end else begin
               // place after any equal entries
               pos = 0;
               while (pos < fill_q && table_q[pos] <= val) pos++;
               for (int j = fill_q; j > pos; j--) table_q[j] = table_q[j-1];
               table_q[pos] = val;
               fill_q++;
            end
            rsp.count = COUNT_W'(fill_q);
            expected_q.push_back(rsp);
         end
         CMD_REMOVE: begin
            keep = 0;
            for (int i = 0; i < fill_q; i++) begin
               if (table_q[i] != val) begin
                  table_q[keep] = table_q[i];
                  keep++;
               end
            end
            fill_q = keep;
            rsp.count = COUNT_W'(fill_q);
            expected_q.push_back(rsp);
         end
         CMD_DUMP: begin
            rsp.count = COUNT_W'(fill_q);
            if (fill_q == 0) begin
               expected_q.push_back(rsp);
            end else begin
               for (int i = 0; i < fill_q; i++) begin
                  rsp.entry_value = table_q[i];
                  rsp.has_value   = 1'b1;
                  rsp.last        = (i == fill_q - 1);
                  expected_q.push_back(rsp);
               end
            end
         end
         default: begin
            rsp.count = COUNT_W'(fill_q);
            expected_q.push_back(rsp);
         end
      endcase
   endtask

   always @(posedge clock) begin
      list_rsp_type want;
      if (reset) begin
         fill_q     = 0;
         fail_count = 0;
         expected_q.delete();
      end else begin
         // predict first so that a same-cycle result still finds its entry
         if (req_valid && !req_stall) begin
            predict_command(req_cmd, req_value);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               report_mismatch("result transfer with nothing outstanding", 32'(rsp_entry_value), '0);
            end else begin
               want = expected_q.pop_front();
               check_field("entry_value", 32'(rsp_entry_value), 32'(want.entry_value));
               check_field("has_value", 32'(rsp_has_value), 32'(want.has_value));
               check_field("last", 32'(rsp_last), 32'(want.last));
               check_field("status", 32'(rsp_status), 32'(want.status));
               check_field("count", 32'(rsp_count), 32'(want.count));
            end
         end
      end
      pending = expected_q.size();
   end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list testbench top
// Drives insert, remove, dump and spare commands with random gaps and
// back-pressure, and gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------

module tb_top import sli_pkg::*; ();

   localparam int CAPACITY     = 16;
   localparam int DIRECTED     = 16;
   localparam int RANDOM_ITEMS = 205;
   localparam int IDLE_LIMIT   = 4000;
   localparam int TAIL_CYCLES  = 40;
   localparam int POOL_SIZE    = 6;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [1:0]                req_cmd;
   logic signed [ENTRY_W-1:0] req_value;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic signed [ENTRY_W-1:0] rsp_entry_value;
   logic                      rsp_has_value;
   logic                      rsp_last;
   logic                      rsp_status;
   logic [COUNT_W-1:0]        rsp_count;

   int          fail_count;
   int          pending;
   int          items_sent;
   int          idle_cycles;
   logic        quiet;
   logic [31:0] pool [POOL_SIZE];

   always #6 clock = ~clock;

   sorted_list_insert_remove #(.CAPACITY(CAPACITY)) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_entry_value (rsp_entry_value),
      .rsp_has_value   (rsp_has_value),
      .rsp_last        (rsp_last),
      .rsp_status      (rsp_status),
      .rsp_count       (rsp_count)
   );

   sorted_list_checker #(.CAPACITY(CAPACITY)) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_entry_value (rsp_entry_value),
      .rsp_has_value   (rsp_has_value),
      .rsp_last        (rsp_last),
      .rsp_status      (rsp_status),
      .rsp_count       (rsp_count),
      .fail_count      (fail_count),
      .pending         (pending)
   );

   function automatic int draw_gap();
      if (quiet) return 0;
      return $urandom_range(0, 12);
   endfunction

   function automatic logic [31:0] pick_value();
      if ($urandom_range(0, 4) == 0) return $urandom();
      return pool[$urandom_range(0, POOL_SIZE - 1)];
   endfunction

   // Called just after a falling edge; returns just after the falling edge
   // that follows the transfer, with valid still high.
   task automatic send_item(input list_cmd_type cmd, input logic [31:0] val);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_cmd   = cmd;
      req_value = val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic wait_for_drain();
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   // Receiver: hold off for a drawn number of cycles before each transfer.
   initial begin
      int hold;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         hold = draw_gap();
         if (hold > 0) begin
            rsp_stall = 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall = 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      int pick;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_cmd     = CMD_INSERT;
      req_value   = '0;
      items_sent  = 0;
      quiet       = 1'b0;
      foreach (pool[k]) pool[k] = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty table, single entry, extremes and duplicates
      send_item(CMD_DUMP, 32'h0);
      send_item(CMD_REMOVE, 32'd7);
      send_item(CMD_SPARE, $urandom());
      send_item(CMD_INSERT, 32'd1);
      send_item(CMD_REMOVE, 32'd1);
      send_item(CMD_INSERT, 32'h7FFF_FFFF);
      send_item(CMD_INSERT, 32'h8000_0000);
      send_item(CMD_INSERT, 32'h0);
      send_item(CMD_INSERT, 32'hFFFF_FFFF);
      send_item(CMD_INSERT, 32'd5);
      send_item(CMD_INSERT, 32'd5);
      send_item(CMD_INSERT, 32'd5);
      send_item(CMD_DUMP, $urandom());
      send_item(CMD_REMOVE, 32'd5);
      send_item(CMD_REMOVE, 32'd42);
      send_item(CMD_DUMP, $urandom());
      wait_for_drain();

      while (items_sent < DIRECTED + RANDOM_ITEMS) begin
         quiet = ($urandom_range(0, 3) == 0);
         // small pools make duplicates and matching removes common
         foreach (pool[k]) begin
            case ($urandom_range(0, 3))
               0: pool[k] = 32'($signed($urandom_range(0, 8)) - 4);
               1: pool[k] = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
               default: pool[k] = $urandom();
            endcase
         end
         case ($urandom_range(0, 3))
            2: begin
               // fill to the top and press past it
               repeat (CAPACITY + 2) send_item(CMD_INSERT, pick_value());
               send_item(CMD_DUMP, $urandom());
            end
            3: begin
               foreach (pool[k]) send_item(CMD_REMOVE, pool[k]);
               send_item(CMD_DUMP, $urandom());
            end
            default: begin
               repeat (12) begin
                  pick = $urandom_range(0, 19);
                  if (pick < 9)       send_item(CMD_INSERT, pick_value());
                  else if (pick < 15) send_item(CMD_REMOVE, pick_value());
                  else if (pick < 19) send_item(CMD_DUMP, $urandom());
                  else                send_item(CMD_SPARE, $urandom());
               end
            end
         endcase
         if ($urandom_range(0, 2) == 0) wait_for_drain();
      end

      wait_for_drain();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+hdl
hdl/sli_pkg.sv
hdl/sli_cell.sv
hdl/sorted_list_insert_remove.sv
tb/sv/sorted_list_checker.sv
tb/sv/tb_top.sv
